>>> rtl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
package ole_pkg;

   localparam int unsigned POS_W      = 7;
   localparam int unsigned ITEM_W     = 32;
   localparam int unsigned CNT_FLD_W  = 7;

   typedef enum logic [2:0] {
      OP_APPEND   = 3'd0,
      OP_INSERT   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_REMOVE   = 3'd3,
      OP_SET      = 3'd4,
      OP_GET      = 3'd5,
      OP_GET_LAST = 3'd6
   } req_op_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_LOAD,
      ACT_TAKE_LEFT,
      ACT_TAKE_RIGHT
   } cell_act_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [POS_W-1:0]  position;
      logic [ITEM_W-1:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic                 ok;
      logic [ITEM_W-1:0]    item_read;
      logic [CNT_FLD_W-1:0] entry_count;
   } rsp_word_type;

   // per-cell control from the sequencer
   typedef struct packed {
      cell_act_type act;
      logic         capture;
      logic         live;
      logic         tap_sel;
   } cell_ctl_type;

endpackage

>>> rtl/ole_cell.sv
// One entry cell of the list chain: holds an entry, shifts, compares, taps.
module ole_cell #(
   parameter int unsigned ITEM_BITS = 32
) (
   input  logic                  clock,
   input  ole_pkg::cell_ctl_type ctl,
   input  logic [ITEM_BITS-1:0]  cap_val,
   input  logic [ITEM_BITS-1:0]  load_val,
   input  logic [ITEM_BITS-1:0]  left_val,
   input  logic [ITEM_BITS-1:0]  right_val,
   output logic [ITEM_BITS-1:0]  entry_val,
   output logic                  match,
   output logic [ITEM_BITS-1:0]  tap
);

   logic [ITEM_BITS-1:0] entry_ff, entry_in;
   logic                 match_ff, match_in;
   logic [ITEM_BITS-1:0] tap_ff, tap_in;

   always_comb begin
      case (ctl.act)
         ole_pkg::ACT_LOAD:       entry_in = load_val;
         ole_pkg::ACT_TAKE_LEFT:  entry_in = left_val;
         ole_pkg::ACT_TAKE_RIGHT: entry_in = right_val;
         default:                 entry_in = entry_ff;
      endcase
   end

   always_comb begin
      match_in = match_ff;
      tap_in   = tap_ff;
      if (ctl.capture) begin
         match_in = ctl.live && (entry_ff == cap_val);
         tap_in   = ctl.tap_sel ? entry_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
      tap_ff   <= tap_in;
   end

   assign entry_val = entry_ff;
   assign match     = match_ff;
   assign tap       = tap_ff;

endmodule

>>> rtl/ole_rsp_fifo.sv
// Two-word result queue between the list sequencer and the result channel.
module ole_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ole_pkg::rsp_word_type push_word,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ole_pkg::rsp_word_type rsp_word
);

   ole_pkg::rsp_word_type slot0_ff, slot0_in;
   ole_pkg::rsp_word_type slot1_ff, slot1_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  pop;
   logic [1:0]            target;

   assign pop = (fill_ff != 2'd0) && !rsp_stall;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      target = fill_ff - {1'b0, pop};
      if (push) begin
         if (target == 2'd0) begin
            slot0_in = push_word;
         end else begin
            slot1_in = push_word;
         end
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (fill_ff == 2'd2);
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_word  = slot0_ff;

endmodule

>>> rtl/ordered_list_engine_core.sv
// Ordered list engine top level: sequencer, chain of entry cells, result queue.
//
// Holds an ordered list of up to CAPACITY entries in a row of cells that
// shift up, shift down, load or hold in parallel. Each request word passes
// an accept step and an execute step: in the accept cycle every cell
// compares its entry with the request value and latches its read tap; in the
// following cycle the cells shift or load and the result word is queued.
// No new request is taken while a request executes, and none while the
// result queue is full. Results wait in a two-word queue, so requests keep
// flowing while the result side stalls for up to two words. Entries hold
// no reset value; only the count, state and queue fill are reset.
module ordered_list_engine_core #(
   parameter int unsigned CAPACITY  = 64,
   parameter int unsigned ITEM_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ole_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ole_pkg::rsp_word_type rsp_word
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;

   ole_pkg::fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [2:0]             op_ff;
   logic [ole_pkg::POS_W-1:0] pos_ff;
   logic [ITEM_BITS-1:0]   val_ff;

   logic                   req_accept;
   logic                   exec;
   logic                   fifo_full;
   logic                   push;
   ole_pkg::rsp_word_type  push_word;

   logic [ITEM_BITS-1:0]   cap_val;
   logic [CMP_W-1:0]       req_pos_ext, cnt_ext, pos_ext, last_ext;

   logic [ITEM_BITS-1:0]   entry_vec [CAPACITY];
   logic [ITEM_BITS-1:0]   tap_vec   [CAPACITY];
   logic [CAPACITY-1:0]    match_vec;
   logic [CAPACITY-1:0]    shift_en;
   logic [CAPACITY-1:0]    load_vec;
   logic                   found;
   logic [ITEM_BITS-1:0]   rd_val;

   logic                   full, empty, pos_lt, pos_le, val_nz;
   logic                   ok;
   logic [CNT_W-1:0]       new_count;
   logic [ITEM_BITS-1:0]   item_out;

   ole_pkg::cell_ctl_type  ctl_vec [CAPACITY];

   // ---------------- sequencer ----------------
   assign req_accept = req_valid && !req_stall;
   assign exec       = (state_ff == ole_pkg::ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ole_pkg::ST_IDLE: if (req_accept) state_in = ole_pkg::ST_EXEC;
         ole_pkg::ST_EXEC: state_in = ole_pkg::ST_IDLE;
         default:          state_in = ole_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      unique case (state_ff)
         ole_pkg::ST_IDLE: req_stall = fifo_full || reset;
         ole_pkg::ST_EXEC: push = 1'b1;
         default:          req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      if (req_accept) begin
         op_ff  <= req_word.req_type;
         pos_ff <= req_word.position;
         val_ff <= ITEM_BITS'(req_word.item_value);
      end
   end

   // ---------------- capture-side compares ----------------
   assign cap_val     = ITEM_BITS'(req_word.item_value);
   assign req_pos_ext = CMP_W'(req_word.position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign last_ext    = cnt_ext - CMP_W'(1);
   assign pos_ext     = CMP_W'(pos_ff);

   // ---------------- execute-side decisions ----------------
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign pos_lt = (pos_ext < cnt_ext);
   assign pos_le = (pos_ext <= cnt_ext);
   assign val_nz = (val_ff != '0);

   // cells at or above the first match shift down
   assign found    = |match_vec;
   assign shift_en = ~((match_vec - CAPACITY'(1)) & ~match_vec);

   always_comb begin
      rd_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_val = rd_val | tap_vec[i];
      end
   end

   always_comb begin
      ok        = 1'b0;
      new_count = count_ff;
      item_out  = '0;
      case (op_ff)
         ole_pkg::OP_APPEND: begin
            ok = val_nz && !full;
            if (ok) new_count = count_ff + CNT_W'(1);
         end
         ole_pkg::OP_INSERT: begin
            ok = pos_le && !full;
            if (ok) new_count = count_ff + CNT_W'(1);
         end
         ole_pkg::OP_DELETE: begin
            ok = pos_lt;
            if (ok) new_count = count_ff - CNT_W'(1);
         end
         ole_pkg::OP_REMOVE: begin
            ok = found;
            if (ok) new_count = count_ff - CNT_W'(1);
         end
         ole_pkg::OP_SET: begin
            ok = val_nz && !empty;
         end
         ole_pkg::OP_GET: begin
            ok       = pos_lt;
            item_out = rd_val;
         end
         ole_pkg::OP_GET_LAST: begin
            ok       = !empty;
            item_out = rd_val;
         end
         default: ok = 1'b0;
      endcase
   end

   assign count_in = exec ? new_count : count_ff;

   assign push_word.ok          = ok;
   assign push_word.item_read   = ole_pkg::ITEM_W'(item_out);
   assign push_word.entry_count = ole_pkg::CNT_FLD_W'(new_count);

   // ---------------- cell chain ----------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
      logic [ITEM_BITS-1:0] left_val, right_val;

      if (g == 0) begin : g_first
         assign left_val = entry_vec[g];
      end else begin : g_mid_l
         assign left_val = entry_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_val = entry_vec[g];
      end else begin : g_mid_r
         assign right_val = entry_vec[g+1];
      end

      always_comb begin
         ctl_vec[g].capture = req_accept;
         ctl_vec[g].live    = (IDX < cnt_ext);
         ctl_vec[g].tap_sel = 1'b0;
         if (req_word.req_type == ole_pkg::OP_GET) begin
            ctl_vec[g].tap_sel = (IDX == req_pos_ext) && (req_pos_ext < cnt_ext);
         end else if (req_word.req_type == ole_pkg::OP_GET_LAST) begin
            ctl_vec[g].tap_sel = !empty && (IDX == last_ext);
         end
         ctl_vec[g].act = ole_pkg::ACT_HOLD;
         if (exec && ok) begin
            case (op_ff)
               ole_pkg::OP_APPEND:
                  if (IDX == cnt_ext) ctl_vec[g].act = ole_pkg::ACT_LOAD;
               ole_pkg::OP_INSERT: begin
                  if (IDX == pos_ext) ctl_vec[g].act = ole_pkg::ACT_LOAD;
                  else if (IDX > pos_ext) ctl_vec[g].act = ole_pkg::ACT_TAKE_LEFT;
               end
               ole_pkg::OP_DELETE:
                  if (IDX >= pos_ext) ctl_vec[g].act = ole_pkg::ACT_TAKE_RIGHT;
               ole_pkg::OP_REMOVE:
                  if (shift_en[g]) ctl_vec[g].act = ole_pkg::ACT_TAKE_RIGHT;
               ole_pkg::OP_SET:
                  if (pos_lt && (IDX == pos_ext)) ctl_vec[g].act = ole_pkg::ACT_LOAD;
               default: ctl_vec[g].act = ole_pkg::ACT_HOLD;
            endcase
         end
      end

      assign load_vec[g] = (ctl_vec[g].act == ole_pkg::ACT_LOAD);

      ole_cell #(
         .ITEM_BITS (ITEM_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl_vec[g]),
         .cap_val   (cap_val),
         .load_val  (val_ff),
         .left_val  (left_val),
         .right_val (right_val),
         .entry_val (entry_vec[g]),
         .match     (match_vec[g]),
         .tap       (tap_vec[g])
      );
   end

   // ---------------- result queue ----------------
   ole_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_accept)
      else $error("request taken during execute cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) ||
               (count_ff == $past(count_ff) + CNT_W'(1)) ||
               (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count beyond capacity");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one cell loading");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("result pushed into full queue");
`endif

endmodule
